// ----- hdl/cmvm_pkg.sv -----
// Shared widths and types of the conjugate vector-matrix accumulator.
`default_nettype none

package cmvm_pkg;

   localparam int ELEM_W = 16;
   localparam int PROD_W = 33;
   localparam int ACC_W  = 48;
   localparam int COL_W  = 6;
   localparam int CFG_W  = 7;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic [COL_W-1:0]         col_type;
   typedef logic [CFG_W-1:0]         cfg_type;

   typedef struct packed {
      acc_type re;
      acc_type im;
   } acc_pair_type;

endpackage

`default_nettype wire

// ----- hdl/cmvm_if.sv -----
// Request, response and register-write channel interfaces of the accumulator.
`default_nettype none

interface cmvm_req_if;
   import cmvm_pkg::*;

   logic     valid;
   logic     ready;
   elem_type elem_re;
   elem_type elem_im;
   elem_type vec_re;
   elem_type vec_im;
   col_type  column;
   logic     final_element;

   modport source (
      output valid, elem_re, elem_im, vec_re, vec_im, column, final_element,
      input  ready
   );
   modport sink (
      input  valid, elem_re, elem_im, vec_re, vec_im, column, final_element,
      output ready
   );
endinterface

interface cmvm_rsp_if;
   import cmvm_pkg::*;

   logic    valid;
   logic    ready;
   acc_type sum_re;
   acc_type sum_im;
   col_type out_column;
   logic    last_column;

   modport source (
      output valid, sum_re, sum_im, out_column, last_column,
      input  ready
   );
   modport sink (
      input  valid, sum_re, sum_im, out_column, last_column,
      output ready
   );
endinterface

interface cmvm_csr_if;
   import cmvm_pkg::*;

   logic    valid;
   logic    ready;
   cfg_type columns_in_use;

   modport source (
      output valid, columns_in_use,
      input  ready
   );
   modport sink (
      input  valid, columns_in_use,
      output ready
   );
endinterface

`default_nettype wire

// ----- hdl/complex_conj_vector_matrix_accumulate_core.sv -----
// Top level of the conjugate vector-matrix accumulator (v^H A, column sums).
`default_nettype none

// Every request carries one matrix element, the vector element of its row and
// the column index; the block adds A*conj(v) into that column's 48-bit complex
// sum held in one RAM. While accumulating, a request is taken every cycle:
// a three-stage read-multiply-add-write pipeline around the RAM, with
// forwarding from the two most recent writes, keeps back-to-back requests to
// the same column exact. A request marked final stops intake, waits for the
// pipeline to drain, and then reads out columns 0 to columns_in_use-1 (at
// least one, at most min(MAX_COLS, 64)), each through address, RAM read and
// response register steps, holding while the response side stalls. Per-column
// valid bits make the store read as zero after reset and after each readout,
// so there is no clearing pass. Register writes are taken at any time.

module complex_conj_vector_matrix_accumulate_core #(
   parameter int MAX_COLS = 64
) (
   input wire logic   clock,
   input wire logic   reset,
   cmvm_req_if.sink   req_chan,
   cmvm_rsp_if.source rsp_chan,
   cmvm_csr_if.sink   csr_chan
);
   import cmvm_pkg::*;

   localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RD_LIMIT_INT = (MAX_COLS < 64) ? MAX_COLS : 64;
   localparam cfg_type RD_LIMIT = CFG_W'(RD_LIMIT_INT);
   localparam cfg_type CFG_RESET = CFG_W'(64);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_DRAIN   = 3'd1;
   localparam logic [2:0] ST_RD_ADDR = 3'd2;
   localparam logic [2:0] ST_RD_DATA = 3'd3;
   localparam logic [2:0] ST_RD_HOLD = 3'd4;

   logic [2:0]          state_ff, state_in;
   cfg_type             columns_in_use_ff;
   col_type             rd_idx_ff, rd_idx_in;
   col_type             rd_last_ff, rd_last_in;
   cfg_type             rd_count;
   logic [MAX_COLS-1:0] valid_ff;

   logic                req_accept, rsp_accept;

   logic                s1_valid_ff;
   logic [AW-1:0]       s1_addr_ff;
   elem_type            s1_ar_ff, s1_ai_ff, s1_vr_ff, s1_vi_ff;

   logic                s2_valid_ff;
   logic [AW-1:0]       s2_addr_ff;
   logic                s2_rvalid_ff;
   logic signed [2*ELEM_W-1:0] s2_rr_ff, s2_ii_ff, s2_ir_ff, s2_ri_ff;
   prod_type            s2_pre, s2_pim;
   acc_pair_type        s2_old;

   logic                s3_valid_ff;
   logic [AW-1:0]       s3_addr_ff;
   acc_pair_type        s3_acc_ff;
   prod_type            s3_pre_ff, s3_pim_ff;
   acc_pair_type        s3_new;

   logic                s4_valid_ff;
   logic [AW-1:0]       s4_addr_ff;
   acc_pair_type        s4_data_ff;

   logic [AW-1:0]       ram_rd_addr;
   logic [2*ACC_W-1:0]  ram_rd_data;
   acc_pair_type        ram_word;

   logic                rsp_valid_ff;
   acc_pair_type        rsp_sum_ff;
   col_type             rsp_col_ff;
   logic                rsp_last_ff;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign rsp_accept = rsp_chan.valid && rsp_chan.ready;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_in_use_ff <= CFG_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         columns_in_use_ff <= csr_chan.columns_in_use;
      end
   end

   always_comb begin
      if (columns_in_use_ff == '0) begin
         rd_count = CFG_W'(1);
      end else if (columns_in_use_ff > RD_LIMIT) begin
         rd_count = RD_LIMIT;
      end else begin
         rd_count = columns_in_use_ff;
      end
   end

   // Accumulation pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept && (int'(req_chan.column) < MAX_COLS);
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff   <= AW'(req_chan.column);
      s1_ar_ff     <= req_chan.elem_re;
      s1_ai_ff     <= req_chan.elem_im;
      s1_vr_ff     <= req_chan.vec_re;
      s1_vi_ff     <= req_chan.vec_im;

      s2_addr_ff   <= s1_addr_ff;
      s2_rvalid_ff <= valid_ff[s1_addr_ff];
      s2_rr_ff     <= s1_ar_ff * s1_vr_ff;
      s2_ii_ff     <= s1_ai_ff * s1_vi_ff;
      s2_ir_ff     <= s1_ai_ff * s1_vr_ff;
      s2_ri_ff     <= s1_ar_ff * s1_vi_ff;

      s3_addr_ff   <= s2_addr_ff;
      s3_acc_ff    <= s2_old;
      s3_pre_ff    <= s2_pre;
      s3_pim_ff    <= s2_pim;

      s4_addr_ff   <= s3_addr_ff;
      s4_data_ff   <= s3_new;
   end

   assign ram_word = acc_pair_type'(ram_rd_data);
   assign s2_pre   = PROD_W'(s2_rr_ff) + PROD_W'(s2_ii_ff);
   assign s2_pim   = PROD_W'(s2_ir_ff) - PROD_W'(s2_ri_ff);

   always_comb begin
      if (s3_valid_ff && (s3_addr_ff == s2_addr_ff)) begin
         s2_old = s3_new;
      end else if (s4_valid_ff && (s4_addr_ff == s2_addr_ff)) begin
         s2_old = s4_data_ff;
      end else if (s2_rvalid_ff) begin
         s2_old = ram_word;
      end else begin
         s2_old = '0;
      end
   end

   assign s3_new.re = s3_acc_ff.re + ACC_W'(s3_pre_ff);
   assign s3_new.im = s3_acc_ff.im + ACC_W'(s3_pim_ff);

   assign ram_rd_addr = (state_ff == ST_RD_ADDR) ? AW'(rd_idx_ff) : s1_addr_ff;

   cmvm_ram #(
      .WIDTH (2 * ACC_W),
      .DEPTH (MAX_COLS)
   ) u_sums (
      .clock   (clock),
      .wr_en   (s3_valid_ff),
      .wr_addr (s3_addr_ff),
      .wr_data (s3_new),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if ((state_ff == ST_RD_HOLD) && rsp_accept && rsp_last_ff) begin
         valid_ff <= '0;
      end else if (s3_valid_ff) begin
         valid_ff[s3_addr_ff] <= 1'b1;
      end
   end

   // Readout sequencer.
   always_comb begin
      state_in   = state_ff;
      rd_idx_in  = rd_idx_ff;
      rd_last_in = rd_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_chan.final_element) begin
               state_in   = ST_DRAIN;
               rd_idx_in  = '0;
               rd_last_in = COL_W'(rd_count - CFG_W'(1));
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff && !s3_valid_ff) begin
               state_in = ST_RD_ADDR;
            end
         end
         ST_RD_ADDR: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            state_in = ST_RD_HOLD;
         end
         ST_RD_HOLD: begin
            if (rsp_accept) begin
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in  = ST_RD_ADDR;
                  rd_idx_in = rd_idx_ff + COL_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_idx_ff  <= '0;
         rd_last_ff <= '0;
      end else begin
         state_ff   <= state_in;
         rd_idx_ff  <= rd_idx_in;
         rd_last_ff <= rd_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_RD_DATA) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_RD_DATA) begin
         rsp_sum_ff  <= valid_ff[AW'(rd_idx_ff)] ? ram_word : '0;
         rsp_col_ff  <= rd_idx_ff;
         rsp_last_ff <= (rd_idx_ff == rd_last_ff);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.sum_re      = rsp_sum_ff.re;
   assign rsp_chan.sum_im      = rsp_sum_ff.im;
   assign rsp_chan.out_column  = rsp_col_ff;
   assign rsp_chan.last_column = rsp_last_ff;

   a_no_write_in_readout: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (state_ff == ST_IDLE || state_ff == ST_DRAIN))
      else $error("Accumulator write during readout.");

   a_drained_before_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_ADDR) |-> (!s1_valid_ff && !s2_valid_ff && !s3_valid_ff))
      else $error("Readout started with accumulations in flight.");

   a_cleared_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_last_ff) |=> (valid_ff == '0 && state_ff == ST_IDLE))
      else $error("Store not cleared after the final column.");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && !rsp_last_ff) |=> (rd_idx_ff == $past(rd_idx_ff) + COL_W'(1)))
      else $error("Readout index did not advance by one.");

   a_column_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_col_ff <= rd_last_ff))
      else $error("Response column beyond the columns in use.");

endmodule

`default_nettype wire

// ----- hdl/cmvm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module cmvm_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- verif/tb_complex_conj_vector_matrix_accumulate_core.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the conjugate vector-matrix accumulator with random flow control.
module tb_complex_conj_vector_matrix_accumulate_core;
   import cmvm_pkg::*;

   localparam int MAX_COLS       = 64;
   localparam int REQUEST_TARGET = 360;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 20;

   typedef struct {
      elem_type elem_re;
      elem_type elem_im;
      elem_type vec_re;
      elem_type vec_im;
      col_type  column;
      logic     final_element;
   } element_type;

   typedef struct {
      acc_type sum_re;
      acc_type sum_im;
      col_type out_column;
      logic    last_column;
   } column_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cmvm_req_if req_chan ();
   cmvm_rsp_if rsp_chan ();
   cmvm_csr_if csr_chan ();

   complex_conj_vector_matrix_accumulate_core #(.MAX_COLS(MAX_COLS)) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   acc_pair_type      column_sums [MAX_COLS];
   cfg_type           readout_columns;
   element_type       pending_elements [$];
   column_result_type column_results_due [$];
   element_type       outgoing;
   column_result_type want;
   int                error_count = 0;
   int                queued_count = 0;
   int                req_gap = 0;
   int                rsp_stall = 0;
   int                idle_cycles = 0;
   bit                steady = 1'b0;
   logic              req_taken = 1'b0;

   always #2 clock = ~clock;

   function automatic int readout_length(input cfg_type count);
      if (count == 0) begin
         return 1;
      end
      if (count > MAX_COLS) begin
         return MAX_COLS;
      end
      return count;
   endfunction

   function automatic void clear_column_sums();
      foreach (column_sums[i]) begin
         column_sums[i] = '0;
      end
   endfunction

   // Adds A*conj(v) into the element's column; a final element then reads the store out.
   function automatic void accumulate_element(input element_type e);
      longint            prod_re;
      longint            prod_im;
      column_result_type r;
      int                n;
      prod_re = longint'(e.elem_re) * longint'(e.vec_re)
              + longint'(e.elem_im) * longint'(e.vec_im);
      prod_im = longint'(e.elem_im) * longint'(e.vec_re)
              - longint'(e.elem_re) * longint'(e.vec_im);
      column_sums[e.column].re = column_sums[e.column].re + acc_type'(prod_re);
      column_sums[e.column].im = column_sums[e.column].im + acc_type'(prod_im);
      if (e.final_element) begin
         n = readout_length(readout_columns);
         for (int i = 0; i < n; i++) begin
            r.sum_re      = column_sums[i].re;
            r.sum_im      = column_sums[i].im;
            r.out_column  = col_type'(i);
            r.last_column = (i == n - 1);
            column_results_due.push_back(r);
         end
         clear_column_sums();
      end
   endfunction

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 80) begin
         return $urandom_range(1, 3);
      end else if (r < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic elem_type pick_component();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         return elem_type'(-32768);
      end else if (r < 16) begin
         return elem_type'(32767);
      end else if (r < 20) begin
         return '0;
      end
      return elem_type'($urandom);
   endfunction

   task automatic queue_element(input elem_type are, input elem_type aim, input elem_type vre,
                                input elem_type vim, input col_type col, input logic fin);
      element_type e;
      e = '{are, aim, vre, vim, col, fin};
      pending_elements.push_back(e);
      queued_count++;
   endtask

   task automatic wait_for_drain();
      while (pending_elements.size() != 0 || req_chan.valid
             || column_results_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_column_count(input cfg_type value);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_chan.columns_in_use <= value;
      csr_chan.valid <= 1'b1;
      do @(posedge clock); while (!(csr_chan.valid && csr_chan.ready));
      readout_columns = value;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      steady = ($urandom_range(0, 3) == 0);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (req_gap > 0) begin
            req_chan.valid <= 1'b0;
            req_gap = req_gap - 1;
         end else if (pending_elements.size() > 0) begin
            outgoing = pending_elements.pop_front();
            req_chan.elem_re       <= outgoing.elem_re;
            req_chan.elem_im       <= outgoing.elem_im;
            req_chan.vec_re        <= outgoing.vec_re;
            req_chan.vec_im        <= outgoing.vec_im;
            req_chan.column        <= outgoing.column;
            req_chan.final_element <= outgoing.final_element;
            req_chan.valid         <= 1'b1;
            req_gap = steady ? 0 : idle_length();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (steady) begin
         rsp_chan.ready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
         rsp_stall = ($urandom_range(0, 3) == 0) ? idle_length() : 0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            accumulate_element('{req_chan.elem_re, req_chan.elem_im, req_chan.vec_re,
                                 req_chan.vec_im, req_chan.column, req_chan.final_element});
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (column_results_due.size() == 0) begin
               $display("%0t: unexpected result, actual col %0d re %0d im %0d last %0b",
                        $time, rsp_chan.out_column, rsp_chan.sum_re, rsp_chan.sum_im,
                        rsp_chan.last_column);
               error_count++;
            end else begin
               want = column_results_due.pop_front();
               if (want.sum_re !== rsp_chan.sum_re || want.sum_im !== rsp_chan.sum_im
                   || want.out_column !== rsp_chan.out_column
                   || want.last_column !== rsp_chan.last_column) begin
                  $display({"%0t: mismatch, expected col %0d re %0d im %0d last %0b,",
                            " actual col %0d re %0d im %0d last %0b"},
                           $time, want.out_column, want.sum_re, want.sum_im,
                           want.last_column, rsp_chan.out_column, rsp_chan.sum_re,
                           rsp_chan.sum_im, rsp_chan.last_column);
                  error_count++;
               end
            end
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || (csr_chan.valid && csr_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("Verification failed");
               $finish;
            end
         end
      end
   end

   initial begin
      int       phase;
      int       matrices;
      int       n;
      int       rows;
      int       r;
      cfg_type  setting;
      elem_type vr;
      elem_type vi;
      bit       reversed;
      col_type  col;
      logic     fin;
      req_chan.valid = 1'b0;
      req_chan.elem_re = '0;
      req_chan.elem_im = '0;
      req_chan.vec_re = '0;
      req_chan.vec_im = '0;
      req_chan.column = '0;
      req_chan.final_element = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.columns_in_use = '0;
      clear_column_sums();
      readout_columns = cfg_type'(MAX_COLS);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Extremes of every component, consecutive requests to one column.
      write_column_count(cfg_type'(64));
      queue_element(32767, 32767, 32767, 32767, 0, 1'b0);
      queue_element(-32768, -32768, -32768, -32768, 0, 1'b0);
      queue_element(-32768, 32767, 32767, -32768, 0, 1'b0);
      queue_element(1, -1, -1, 1, 63, 1'b0);
      queue_element(0, 0, -32768, 32767, 63, 1'b0);
      queue_element(-32768, 0, 0, -32768, 1, 1'b0);
      queue_element(32767, -32768, -32768, 32767, 42, 1'b0);
      queue_element(-32768, -32768, 32767, 32767, 21, 1'b1);

      // A column beyond the readout is accumulated but dropped, then cleared.
      write_column_count(cfg_type'(1));
      queue_element(12345, -2222, 333, -4444, 0, 1'b0);
      queue_element(-32768, -32768, -32768, -32768, 40, 1'b0);
      queue_element(-1, -1, -1, -1, 0, 1'b1);
      queue_element(100, 200, 300, 400, 40, 1'b1);

      // A count of zero reads out one column; counts above the store saturate.
      write_column_count(cfg_type'(0));
      queue_element(7, 8, 9, 10, 0, 1'b1);
      queue_element(1, 1, 1, 1, 5, 1'b1);
      write_column_count(cfg_type'(127));
      queue_element(32767, -32768, 32767, -32768, 63, 1'b1);
      write_column_count(cfg_type'(65));
      queue_element(-32768, 32767, -32768, 32767, 62, 1'b1);

      phase = 0;
      while (queued_count < REQUEST_TARGET) begin
         r = $urandom_range(0, 99);
         if (phase == 0) begin
            setting = cfg_type'(64);
         end else if (phase == 1) begin
            setting = cfg_type'(1);
         end else if (r < 60) begin
            setting = cfg_type'($urandom_range(1, 8));
         end else if (r < 80) begin
            setting = cfg_type'($urandom_range(9, 64));
         end else if (r < 90) begin
            setting = ($urandom_range(0, 1) == 0) ? cfg_type'(0)
                                                  : cfg_type'($urandom_range(65, 127));
         end else begin
            setting = cfg_type'(64);
         end
         write_column_count(setting);
         n = readout_length(setting);
         matrices = (n > 16) ? 1 : $urandom_range(1, 3);
         for (int m = 0; m < matrices; m++) begin
            rows = (n > 16) ? 1 : $urandom_range(1, 4);
            reversed = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < rows; i++) begin
               vr = pick_component();
               vi = pick_component();
               for (int j = 0; j < n; j++) begin
                  fin = (i == rows - 1) && (j == n - 1);
                  col = reversed ? col_type'(n - 1 - j) : col_type'(j);
                  if ($urandom_range(0, 9) == 0) begin
                     queue_element(pick_component(), pick_component(), pick_component(),
                                   pick_component(), col_type'($urandom_range(0, 63)), 1'b0);
                  end
                  if (fin || $urandom_range(0, 15) != 0) begin
                     queue_element(pick_component(), pick_component(), vr, vi, col, fin);
                  end
               end
            end
         end
         phase++;
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && column_results_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/cmvm_pkg.sv
hdl/cmvm_if.sv
hdl/cmvm_ram.sv
hdl/complex_conj_vector_matrix_accumulate_core.sv
verif/tb_complex_conj_vector_matrix_accumulate_core.sv
